FILE: rtl/fixed_block_buffer_pool_core_defines.svh
// Assertion shorthands for the buffer allocator checkers.
`ifndef FIXED_BLOCK_BUFFER_POOL_CORE_DEFINES_SVH
`define FIXED_BLOCK_BUFFER_POOL_CORE_DEFINES_SVH

// Same-cycle implication, gated off during reset.
`define FBBP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off during reset.
`define FBBP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/fbbp_pkg.sv
package fbbp_pkg;

   localparam int FBBP_NUM_BUFFERS = 32;
   localparam int ADDR_W           = 32;
   localparam int BYTES_W          = 16;
   localparam int ACTIVE_W         = 6;
   localparam int INDEX_W          = 5;
   localparam int CSR_AW           = 4;
   localparam int CSR_DW           = 32;

   localparam logic [BYTES_W-1:0]  BYTES_RESET  = BYTES_W'(64);
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(32);

   typedef enum logic [1:0] {
      OP_ACQUIRE  = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_FIND     = 2'd2,
      OP_FREE_ALL = 2'd3
   } fbbp_op_type;

   typedef enum logic [1:0] {
      CSR_BASE   = 2'd0,
      CSR_BYTES  = 2'd1,
      CSR_ACTIVE = 2'd2
   } fbbp_csr_type;

   // what goes into the result holding register
   typedef enum logic [1:0] {
      CAP_HIT,
      CAP_MISS,
      CAP_DONE
   } fbbp_cap_type;

   typedef struct packed {
      logic         load;
      logic         scan;
      logic         fill;
      logic         capture;
      fbbp_cap_type kind;
      logic         emit;
   } fbbp_cmd_type;

   typedef struct packed {
      logic hit;
      logic rd_vld;
      logic rd_last;
      logic init_last;
      logic sweep_last;
      logic count_zero;
      logic out_free;
   } fbbp_sts_type;

endpackage

FILE: rtl/fbbp_req_if.sv
interface fbbp_req_if;
   import fbbp_pkg::*;

   logic              valid;
   logic              ready;
   fbbp_op_type       opcode;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink   (input valid, input opcode, input address, output ready);
endinterface

FILE: rtl/fbbp_rsp_if.sv
interface fbbp_rsp_if;
   import fbbp_pkg::*;

   logic               valid;
   logic               ready;
   logic               status;
   logic [ADDR_W-1:0]  buffer_address;
   logic [INDEX_W-1:0] buffer_index;
   logic [BYTES_W-1:0] capacity;
   logic               in_use;

   modport source (output valid, output status, output buffer_address, output buffer_index,
                   output capacity, output in_use, input ready);
   modport sink   (input valid, input status, input buffer_address, input buffer_index,
                   input capacity, input in_use, output ready);
endinterface

FILE: rtl/fixed_block_buffer_pool_core.sv
// Fixed-size buffer allocator. A region at base_address is cut into buffers of
// buffer_bytes each; buffer i starts at base_address + i*buffer_bytes (mod 2^32).
// Request beats carry an opcode (acquire, release by address, find by address,
// free all); every request beat yields exactly one response beat. The free flags
// sit in a memory with one read and one write port that is walked one buffer per
// clock: acquire/release/find scan up to the first match (or the last usable
// buffer on a miss), free all marks the usable flags free, and a request on an
// empty pool is answered at once. The result then goes to the response register,
// and only after that is the next request taken. After reset a clearing pass
// marks all NUM_BUFFERS flags free with req ready held low; CSR writes are taken
// at any time. Config registers live at byte offsets 0x0 (base_address), 0x4
// (buffer_bytes), 0x8 (active_buffers) and must only be written while no
// request is in flight.
module fixed_block_buffer_pool_core #(
   parameter int NUM_BUFFERS = fbbp_pkg::FBBP_NUM_BUFFERS
) (
   input  logic                          clock,
   input  logic                          reset,
   fbbp_req_if.sink                      req_ch,
   fbbp_rsp_if.source                    rsp_ch,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fbbp_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [fbbp_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [fbbp_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import fbbp_pkg::*;

   // config registers
   logic [ADDR_W-1:0]   base_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic [ACTIVE_W-1:0] active_ff;

   fbbp_csr_type csr_sel;
   logic         csr_wr;

   fbbp_cmd_type cmd;
   fbbp_sts_type sts;

   // register select ignores the byte lane bits
   assign csr_sel    = fbbp_csr_type'(csr_paddr[CSR_AW-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= '0;
         bytes_ff  <= BYTES_RESET;
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr) begin
         case (csr_sel)
            CSR_BASE:   base_ff   <= csr_pwdata[ADDR_W-1:0];
            CSR_BYTES:  bytes_ff  <= csr_pwdata[BYTES_W-1:0];
            CSR_ACTIVE: active_ff <= csr_pwdata[ACTIVE_W-1:0];
            default: begin
               // unmapped offset, write dropped
            end
         endcase
      end
   end

   always_comb begin
      case (csr_sel)
         CSR_BASE:   csr_prdata = CSR_DW'(base_ff);
         CSR_BYTES:  csr_prdata = CSR_DW'(bytes_ff);
         CSR_ACTIVE: csr_prdata = CSR_DW'(active_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // sequencer: clearing pass, scan, sweep, response hand-off
   fbbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // flag memory, address walker, result and response registers
   fbbp_dp #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_opcode         (req_ch.opcode),
      .req_address        (req_ch.address),
      .base_address       (base_ff),
      .buffer_bytes       (bytes_ff),
      .active_buffers     (active_ff),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_status         (rsp_ch.status),
      .rsp_buffer_address (rsp_ch.buffer_address),
      .rsp_buffer_index   (rsp_ch.buffer_index),
      .rsp_capacity       (rsp_ch.capacity),
      .rsp_in_use         (rsp_ch.in_use)
   );

endmodule

FILE: rtl/fbbp_ctrl.sv
module fbbp_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  fbbp_pkg::fbbp_op_type  req_opcode,
   output logic                   req_ready,
   input  fbbp_pkg::fbbp_sts_type sts,
   output fbbp_pkg::fbbp_cmd_type cmd
);
   import fbbp_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_SWEEP,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      req_ready_ff;

   assign req_ready = req_ready_ff;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.kind    = CAP_DONE;
      case (state_ff)
         ST_INIT: begin
            cmd.fill = 1'b1;
            if (sts.init_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               if (sts.count_zero) begin
                  // empty pool: free-all succeeds, the rest fail at once
                  cmd.capture = 1'b1;
                  cmd.kind    = (req_opcode == OP_FREE_ALL) ? CAP_DONE : CAP_MISS;
                  state_in    = ST_EMIT;
               end else if (req_opcode == OP_FREE_ALL) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.rd_vld) begin
               if (sts.hit) begin
                  cmd.capture = 1'b1;
                  cmd.kind    = CAP_HIT;
                  state_in    = ST_EMIT;
               end else if (sts.rd_last) begin
                  cmd.capture = 1'b1;
                  cmd.kind    = CAP_MISS;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_SWEEP: begin
            cmd.fill = 1'b1;
            if (sts.sweep_last) begin
               cmd.capture = 1'b1;
               cmd.kind    = CAP_DONE;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_IDLE);
      end
   end

endmodule

FILE: rtl/fbbp_dp.sv
module fbbp_dp #(
   parameter int NUM_BUFFERS = fbbp_pkg::FBBP_NUM_BUFFERS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fbbp_pkg::fbbp_cmd_type          cmd,
   output fbbp_pkg::fbbp_sts_type          sts,
   input  fbbp_pkg::fbbp_op_type           req_opcode,
   input  logic [fbbp_pkg::ADDR_W-1:0]     req_address,
   input  logic [fbbp_pkg::ADDR_W-1:0]     base_address,
   input  logic [fbbp_pkg::BYTES_W-1:0]    buffer_bytes,
   input  logic [fbbp_pkg::ACTIVE_W-1:0]   active_buffers,
   input  logic                            rsp_ready,
   output logic                            rsp_valid,
   output logic                            rsp_status,
   output logic [fbbp_pkg::ADDR_W-1:0]     rsp_buffer_address,
   output logic [fbbp_pkg::INDEX_W-1:0]    rsp_buffer_index,
   output logic [fbbp_pkg::BYTES_W-1:0]    rsp_capacity,
   output logic                            rsp_in_use
);
   import fbbp_pkg::*;

   localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int CW = $clog2(NUM_BUFFERS + 1);
   localparam int MW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

   // free flag per buffer, 1 = free
   logic free_mem [NUM_BUFFERS];

   logic [CW-1:0]      count;
   fbbp_op_type        op_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [CW-1:0]      scan_idx_ff, scan_idx_in;
   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [IW-1:0]      rd_idx_ff;
   logic [ADDR_W-1:0]  rd_start_ff;
   logic               rd_vld_ff, rd_vld_in;
   logic               mem_q_ff;
   logic               wr_en;
   logic [IW-1:0]      wr_idx;
   logic               wr_val;
   logic               hit;
   logic               res_status_ff;
   logic [ADDR_W-1:0]  res_addr_ff;
   logic [INDEX_W-1:0] res_index_ff;
   logic [BYTES_W-1:0] res_cap_ff;
   logic               res_use_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [BYTES_W-1:0] rsp_cap_ff;
   logic               rsp_use_ff;

   // usable buffers: zero size empties the pool, count saturates at the built size
   always_comb begin
      if (buffer_bytes == '0) begin
         count = '0;
      end else if (MW'(active_buffers) > MW'(NUM_BUFFERS)) begin
         count = CW'(NUM_BUFFERS);
      end else begin
         count = CW'(active_buffers);
      end
   end

   always_comb begin
      scan_idx_in = scan_idx_ff;
      start_in    = start_ff;
      if (cmd.load) begin
         scan_idx_in = '0;
         start_in    = base_address;
      end else if (cmd.scan || cmd.fill) begin
         scan_idx_in = scan_idx_ff + CW'(1);
         start_in    = start_ff + ADDR_W'(buffer_bytes);
      end
      rd_vld_in = cmd.scan && (scan_idx_ff < count);
   end

   assign hit = rd_vld_ff && ((op_ff == OP_ACQUIRE) ? mem_q_ff : (rd_start_ff == addr_ff));

   assign wr_en  = cmd.fill || (cmd.capture && (cmd.kind == CAP_HIT) && (op_ff != OP_FIND));
   assign wr_idx = cmd.fill ? scan_idx_ff[IW-1:0] : rd_idx_ff;
   assign wr_val = cmd.fill || (op_ff == OP_RELEASE);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_mem[wr_idx] <= wr_val;
      end
      mem_q_ff <= free_mem[scan_idx_ff[IW-1:0]];
   end

   assign rsp_valid_in = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         start_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         start_ff     <= start_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
      end
      if (cmd.scan) begin
         rd_idx_ff   <= scan_idx_ff[IW-1:0];
         rd_start_ff <= start_ff;
      end
      if (cmd.capture) begin
         case (cmd.kind)
            CAP_HIT: begin
               res_status_ff <= 1'b0;
               res_addr_ff   <= rd_start_ff;
               res_index_ff  <= INDEX_W'(rd_idx_ff);
               res_cap_ff    <= buffer_bytes;
               case (op_ff)
                  OP_ACQUIRE: res_use_ff <= 1'b1;
                  OP_RELEASE: res_use_ff <= 1'b0;
                  default:    res_use_ff <= !mem_q_ff;
               endcase
            end
            CAP_MISS: begin
               res_status_ff <= 1'b1;
               res_addr_ff   <= '0;
               res_index_ff  <= '0;
               res_cap_ff    <= '0;
               res_use_ff    <= 1'b0;
            end
            default: begin
               res_status_ff <= 1'b0;
               res_addr_ff   <= '0;
               res_index_ff  <= '0;
               res_cap_ff    <= '0;
               res_use_ff    <= 1'b0;
            end
         endcase
      end
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_index_ff  <= res_index_ff;
         rsp_cap_ff    <= res_cap_ff;
         rsp_use_ff    <= res_use_ff;
      end
   end

   always_comb begin
      sts            = '0;
      sts.hit        = hit;
      sts.rd_vld     = rd_vld_ff;
      sts.rd_last    = (CW'(rd_idx_ff) + CW'(1)) == count;
      sts.init_last  = scan_idx_ff == CW'(NUM_BUFFERS - 1);
      sts.sweep_last = (scan_idx_ff + CW'(1)) == count;
      sts.count_zero = count == '0;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_buffer_address = rsp_addr_ff;
   assign rsp_buffer_index   = rsp_index_ff;
   assign rsp_capacity       = rsp_cap_ff;
   assign rsp_in_use         = rsp_use_ff;

endmodule

FILE: rtl/fbbp_checker.sv
`include "fixed_block_buffer_pool_core_defines.svh"

module fbbp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_status,
   input logic [fbbp_pkg::ADDR_W-1:0]   rsp_buffer_address,
   input logic [fbbp_pkg::INDEX_W-1:0]  rsp_buffer_index,
   input logic [fbbp_pkg::BYTES_W-1:0]  rsp_capacity,
   input logic                          rsp_in_use,
   input logic                          csr_psel,
   input logic                          csr_penable,
   input logic                          csr_pwrite,
   input logic [fbbp_pkg::CSR_AW-1:0]   csr_paddr,
   input logic [fbbp_pkg::CSR_DW-1:0]   csr_pwdata,
   input logic [fbbp_pkg::CSR_DW-1:0]   csr_prdata
);
   import fbbp_pkg::*;

   // a failed beat reports nothing
   `FBBP_ASSERT_IMP(a_fail_zero, clock, reset, rsp_valid && rsp_status, (rsp_buffer_address == '0) && (rsp_buffer_index == '0) && (rsp_capacity == '0) && !rsp_in_use, "failed response carries nonzero fields")

   // a buffer reported in use always has a real size
   `FBBP_ASSERT_IMP(a_use_cap, clock, reset, rsp_valid && !rsp_status && rsp_in_use, rsp_capacity != '0, "in-use buffer reported with zero capacity")

   // one request at a time: ready drops right after a request beat
   `FBBP_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   // base register reads back what was written
   `FBBP_ASSERT_NXT(a_base_rb, clock, reset, csr_psel && csr_penable && csr_pwrite && (csr_paddr[CSR_AW-1:2] == CSR_BASE), !(csr_paddr[CSR_AW-1:2] == CSR_BASE) || (csr_prdata == $past(csr_pwdata)), "base register readback mismatch")

   // stalled response beat holds
   `FBBP_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_buffer_address) && $stable(rsp_buffer_index) && $stable(rsp_capacity) && $stable(rsp_in_use), "stalled response changed")

endmodule

bind fixed_block_buffer_pool_core fbbp_checker u_fbbp_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_status         (rsp_ch.status),
   .rsp_buffer_address (rsp_ch.buffer_address),
   .rsp_buffer_index   (rsp_ch.buffer_index),
   .rsp_capacity       (rsp_ch.capacity),
   .rsp_in_use         (rsp_ch.in_use),
   .csr_psel           (csr_psel),
   .csr_penable        (csr_penable),
   .csr_pwrite         (csr_pwrite),
   .csr_paddr          (csr_paddr),
   .csr_pwdata         (csr_pwdata),
   .csr_prdata         (csr_prdata)
);
